### design/h264_nal_rtp_fragmenter_unit_assert.svh
// Assertion macros shared by the fragmenter modules.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef H264_NAL_RTP_FRAGMENTER_UNIT_ASSERT_SVH
`define H264_NAL_RTP_FRAGMENTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define H264FU_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("h264fu: implication check failed");

// Next-cycle implication, checked out of reset
`define H264FU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("h264fu: next-cycle check failed");

`endif

### design/h264fu_pkg.sv
// Shared types, constants and byte helpers for the NAL to RTP fragmenter.
// No dependencies; every design module imports this package.
`default_nettype none

package h264fu_pkg;

    // Widths and defaults
    localparam int          LENGTH_BITS_DEFAULT = 16;
    localparam int          QUEUE_DEPTH_DEFAULT = 2;
    localparam int          LIMIT_W             = 12;
    localparam logic [11:0] LIMIT_RESET         = 12'd1388;
    localparam logic [11:0] LIMIT_MIN           = 12'd16;
    localparam logic [11:0] FILL_HDR            = 12'd2;

    // FU-A byte fields
    localparam logic [7:0] FU_A_TYPE = 8'h1C;
    localparam logic [7:0] FU_START  = 8'h80;
    localparam logic [7:0] FU_END    = 8'h40;
    localparam logic [7:0] TYPE_MASK = 8'h1F;
    localparam logic [7:0] NRI_MASK  = 8'hE0;

    // Phase of the unit being parsed
    typedef enum logic [1:0] {
        PH_SYNC = 2'd0,
        PH_HEAD = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    // One queued job: the 1 to 3 results caused by one input byte
    typedef struct packed {
        logic [1:0]      last_idx;
        logic [2:0][7:0] data;
        logic            first;
        logic            last;
        logic [31:0]     ts;
    } job_t;

    function automatic logic [7:0] fu_indicator(input logic [7:0] hdr);
        return (hdr & NRI_MASK) | FU_A_TYPE;
    endfunction

    function automatic logic [7:0] fu_header(input logic [7:0] hdr);
        return hdr & TYPE_MASK;
    endfunction

endpackage

`default_nettype wire

### design/h264_nal_rtp_fragmenter_unit.sv
// Top level of the H.264 NAL unit to RTP payload fragmenter.
// Depends on h264fu_pkg, h264fu_front, h264fu_queue and h264fu_back.
//
// Feed one NAL unit per run of bytes, start code included, with the unit's
// total length and timestamp increment on every byte. Start code bytes and
// the marker byte after the zeros produce nothing; each later byte produces
// one payload byte, or three when it opens an FU-A fragment (indicator,
// FU header, data) and two for the NAL header of a fragmented unit. The
// front takes one input byte per cycle while its job queue (QUEUE_DEPTH
// entries) has room; the back sends one result per cycle while out_ready
// is high, so the sustained rate is one result per cycle on the output
// port while the receiver is ready. run_last marks the final result
// of each input byte. payload_limit may be written only while idle; values
// below 16 act as 16. No memory clearing pass runs after reset.
`default_nettype none

module h264_nal_rtp_fragmenter_unit #(
    parameter int LENGTH_BITS = h264fu_pkg::LENGTH_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = h264fu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      nal_byte,
    input  logic [15:0]                     nal_length,
    input  logic [31:0]                     ts_increment,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [h264fu_pkg::LIMIT_W-1:0]  payload_limit,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      pkt_byte,
    output logic                            pkt_first,
    output logic                            pkt_last,
    output logic [31:0]                     ts_step,
    output logic                            run_last
);
    import h264fu_pkg::*;

    logic push;
    logic push_ready;
    job_t push_job;
    logic pop;
    logic pop_valid;
    job_t pop_job;

    h264fu_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .nal_byte      (nal_byte),
        .nal_length    (nal_length),
        .ts_increment  (ts_increment),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .payload_limit (payload_limit),
        .q_ready       (push_ready),
        .q_push        (push),
        .q_job         (push_job)
    );

    h264fu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job)
    );

    h264fu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_job     (pop_job),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pkt_byte  (pkt_byte),
        .pkt_first (pkt_first),
        .pkt_last  (pkt_last),
        .ts_step   (ts_step),
        .run_last  (run_last)
    );

endmodule

`default_nettype wire

### design/h264fu_queue.sv
// Short job queue between the classifying front and the emitting back.
// Depends on h264fu_pkg (job_t). DEPTH must be a power of two.
`default_nettype none

module h264fu_queue #(
    parameter int DEPTH = h264fu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  h264fu_pkg::job_t   push_job,
    output logic               push_ready,
    input  logic               pop,
    output logic               pop_valid,
    output h264fu_pkg::job_t   pop_job
);
    import h264fu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             push_ok, pop_ok;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push_ok    = push && push_ready;
    assign pop_ok     = pop && pop_valid;
    assign pop_job    = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop_ok  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    `include "h264_nal_rtp_fragmenter_unit_assert.svh"

    // simultaneous push and pop leaves the fill unchanged
    `H264FU_ASSERT_NEXT(a_queue_pass_through, push_ok && pop_ok, $stable(count_reg))

endmodule

`default_nettype wire

### design/h264fu_front.sv
// Front end: takes input bytes, strips the start code, decides single packet
// or FU-A fragments; queues one job per later byte. Depends on h264fu_pkg.
`default_nettype none

module h264fu_front #(
    parameter int LENGTH_BITS = h264fu_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      nal_byte,
    input  logic [15:0]                     nal_length,
    input  logic [31:0]                     ts_increment,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [h264fu_pkg::LIMIT_W-1:0]  payload_limit,
    input  logic                            q_ready,
    output logic                            q_push,
    output h264fu_pkg::job_t                q_job
);
    import h264fu_pkg::*;

    localparam int LB = LENGTH_BITS;

    logic [LIMIT_W-1:0] limit_reg;
    phase_t             phase_reg,  phase_next;
    logic [LB-1:0]      taken_reg,  taken_next;
    logic [LB-1:0]      left_reg,   left_next;
    logic [11:0]        fill_reg,   fill_next;
    logic [7:0]         header_reg, header_next;
    logic               frag_reg,   frag_next;
    logic [31:0]        held_reg,   held_next;

    logic               accept;
    logic [11:0]        lim;
    logic [LB-1:0]      lim_ext;
    logic [LB-1:0]      len;
    logic [LB-1:0]      taken_inc;
    logic [LB-1:0]      left_new;
    logic               start_unit;
    logic               last_byte;
    logic               opening;
    logic [11:0]        fill_e;
    logic [11:0]        fill_inc;
    logic               fin;

    assign in_ready  = q_ready;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    // Effective limit and length
    assign lim     = (limit_reg < LIMIT_MIN) ? LIMIT_MIN : limit_reg;
    assign lim_ext = LB'(lim);
    assign len     = LB'(nal_length);

    // Start code tracking
    assign taken_inc  = taken_reg + LB'(1);
    assign left_new   = len - taken_inc;
    assign start_unit = (nal_byte != 8'd0) && (taken_inc < len);
    assign last_byte  = left_reg == LB'(1);

    // Fragment fill tracking
    assign opening  = fill_reg >= lim;
    assign fill_e   = opening ? FILL_HDR : fill_reg;
    assign fill_inc = fill_e + 12'd1;
    assign fin      = ((LB+1)'(left_reg) + (LB+1)'(fill_e)) <= (LB+1)'(lim);

    // Phase next state
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEAD,
                PH_BODY: phase_next = last_byte ? PH_SYNC : PH_BODY;
                default: phase_next = start_unit ? PH_HEAD : PH_SYNC;
            endcase
        end
    end

    // Counters and job build
    always_comb
    begin
        taken_next  = taken_reg;
        left_next   = left_reg;
        fill_next   = fill_reg;
        header_next = header_reg;
        frag_next   = frag_reg;
        held_next   = held_reg;
        q_push      = 1'b0;
        q_job       = '0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEAD:
                begin
                    q_push = 1'b1;
                    if (!frag_reg)
                    begin
                        q_job.data[0] = nal_byte;
                        q_job.first   = 1'b1;
                        q_job.last    = last_byte;
                        q_job.ts      = held_reg;
                    end
                    else
                    begin
                        header_next    = nal_byte;
                        q_job.last_idx = 2'd1;
                        q_job.data[0]  = fu_indicator(nal_byte);
                        q_job.data[1]  = fu_header(nal_byte) | FU_START;
                        q_job.first    = 1'b1;
                        fill_next      = FILL_HDR;
                    end
                    left_next = left_reg - LB'(1);
                end
                PH_BODY:
                begin
                    q_push = 1'b1;
                    if (!frag_reg)
                    begin
                        q_job.data[0] = nal_byte;
                        q_job.last    = last_byte;
                        q_job.ts      = held_reg;
                    end
                    else
                    begin
                        if (opening)
                        begin
                            q_job.last_idx = 2'd2;
                            q_job.data[0]  = fu_indicator(header_reg);
                            q_job.data[1]  = fu_header(header_reg) | (fin ? FU_END : 8'h00);
                            q_job.data[2]  = nal_byte;
                        end
                        else
                        begin
                            q_job.data[0] = nal_byte;
                        end
                        q_job.first = opening;
                        q_job.last  = last_byte || (fill_inc >= lim);
                        q_job.ts    = fin ? held_reg : 32'd0;
                        fill_next   = fill_inc;
                    end
                    left_next = left_reg - LB'(1);
                end
                default:
                begin
                    taken_next = taken_inc;
                    if (start_unit)
                    begin
                        left_next = left_new;
                        frag_next = left_new > lim_ext;
                        held_next = ts_increment;
                        fill_next = '0;
                    end
                    else if (taken_inc >= len)
                    begin
                        taken_next = '0;
                        left_next  = '0;
                        fill_next  = '0;
                        frag_next  = 1'b0;
                    end
                end
            endcase
            // unit over after its last stripped byte
            if ((phase_reg == PH_HEAD || phase_reg == PH_BODY) && last_byte)
            begin
                taken_next = '0;
                left_next  = '0;
                fill_next  = '0;
                frag_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RESET;
            phase_reg  <= PH_SYNC;
            taken_reg  <= '0;
            left_reg   <= '0;
            fill_reg   <= '0;
            header_reg <= '0;
            frag_reg   <= 1'b0;
            held_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= payload_limit;
            end
            phase_reg  <= phase_next;
            taken_reg  <= taken_next;
            left_reg   <= left_next;
            fill_reg   <= fill_next;
            header_reg <= header_next;
            frag_reg   <= frag_next;
            held_reg   <= held_next;
        end
    end

    `include "h264_nal_rtp_fragmenter_unit_assert.svh"

    // fragmenting only ever set while a unit is open
    `H264FU_ASSERT_IMPLY(a_sync_not_frag, phase_reg == PH_SYNC, !frag_reg)
    // a unit in header phase always has bytes left
    `H264FU_ASSERT_IMPLY(a_head_has_left, phase_reg == PH_HEAD, left_reg != '0)

endmodule

`default_nettype wire

### design/h264fu_back.sv
// Back end: walks the queued job at the head and sends its results one
// per transfer on the output channel. Depends on h264fu_pkg (job_t).
`default_nettype none

module h264fu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  h264fu_pkg::job_t  q_job,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        pkt_byte,
    output logic              pkt_first,
    output logic              pkt_last,
    output logic [31:0]       ts_step,
    output logic              run_last
);
    import h264fu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       at_end;
    logic       xfer;

    assign out_valid = q_valid;
    assign xfer      = out_valid && out_ready;
    assign at_end    = idx_reg == q_job.last_idx;
    assign q_pop     = xfer && at_end;

    // Result fields for the current position in the job
    assign pkt_byte  = q_job.data[idx_reg];
    assign pkt_first = q_job.first && (idx_reg == 2'd0);
    assign pkt_last  = q_job.last && at_end;
    assign ts_step   = q_job.ts;
    assign run_last  = at_end;

    // Position within the job
    always_comb
    begin
        idx_next = idx_reg;
        if (xfer)
        begin
            idx_next = at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    `include "h264_nal_rtp_fragmenter_unit_assert.svh"

    // position never runs past the job's last result
    `H264FU_ASSERT_IMPLY(a_idx_in_job, out_valid, idx_reg <= q_job.last_idx)
    // a job cut short by a transfer still has results pending next cycle
    `H264FU_ASSERT_NEXT(a_job_continues, xfer && !run_last, out_valid && idx_reg != 2'd0)

endmodule

`default_nettype wire

### bench/tb_h264_nal_rtp_fragmenter_unit.sv
// Testbench for h264_nal_rtp_fragmenter_unit: streams NAL units through the
// block and checks every payload byte against a predictor held in a class.
// Depends on h264fu_pkg and the design files under design/.

module tb_h264_nal_rtp_fragmenter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import h264fu_pkg::*;

    localparam int HOLD_LEN      = 80;    // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;     // a few times the queue depth
    localparam int STALL_LIMIT   = 1000;  // cycles with no transfer at all
    localparam int MAX_REPORTS   = 40;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 10;

    // One payload byte as seen on the output port
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [31:0] ts;
        logic        run_last;
    } pkt_result_t;

    // One input byte with its side fields
    typedef struct {
        logic [7:0]  data;
        logic [15:0] len;
        logic [31:0] ts;
    } nal_item_t;

    // Predictor and store of expected payload bytes
    class frag_scoreboard;
        logic [11:0] limit;
        phase_t      phase;
        logic [15:0] taken;
        logic [15:0] left;
        logic [11:0] fill;
        logic [7:0]  nal_hdr;
        logic        frag;
        logic [31:0] held_ts;
        pkt_result_t expected_pkt[$];
        int          errors;

        function new();
            limit   = LIMIT_RESET;
            nal_hdr = 8'h00;
            held_ts = 32'd0;
            errors  = 0;
            close_unit();
        endfunction

        function void close_unit();
            phase = PH_SYNC;
            taken = 16'd0;
            left  = 16'd0;
            fill  = 12'd0;
            frag  = 1'b0;
        endfunction

        function void count_down();
            left = left - 16'd1;
            if (left == 16'd0)
                close_unit();
        endfunction

        function pkt_result_t payload_byte(logic [7:0] d, logic f, logic l, logic [31:0] t);
            pkt_result_t r;
            r.data     = d;
            r.first    = f;
            r.last     = l;
            r.ts       = t;
            r.run_last = 1'b0;
            return r;
        endfunction

        // Work out the payload bytes caused by one accepted input byte
        function void take_nal_byte(logic [7:0] b, logic [15:0] len, logic [31:0] ts);
            pkt_result_t made[$];
            logic [11:0] lim;
            logic        opening;
            logic        fin;
            logic [31:0] tsv;
            lim = (limit < LIMIT_MIN) ? LIMIT_MIN : limit;
            if (phase == PH_HEAD) begin
                if (!frag) begin
                    made.push_back(payload_byte(b, 1'b1, left == 16'd1, held_ts));
                end else begin
                    nal_hdr = b;
                    made.push_back(payload_byte((b & NRI_MASK) | FU_A_TYPE, 1'b1, 1'b0, 32'd0));
                    made.push_back(payload_byte((b & TYPE_MASK) | FU_START, 1'b0, 1'b0, 32'd0));
                    fill = FILL_HDR;
                end
                phase = PH_BODY;
                count_down();
            end else if (phase == PH_BODY) begin
                if (!frag) begin
                    made.push_back(payload_byte(b, 1'b0, left == 16'd1, held_ts));
                end else begin
                    opening = (fill >= lim);
                    if (opening)
                        fill = FILL_HDR;
                    fin = ({16'd0, left} + {20'd0, fill}) <= {20'd0, lim};
                    tsv = fin ? held_ts : 32'd0;
                    if (opening) begin
                        made.push_back(payload_byte((nal_hdr & NRI_MASK) | FU_A_TYPE,
                                                    1'b1, 1'b0, tsv));
                        made.push_back(payload_byte((nal_hdr & TYPE_MASK) | (fin ? FU_END : 8'h00),
                                                    1'b0, 1'b0, tsv));
                    end
                    fill = fill + 12'd1;
                    made.push_back(payload_byte(b, 1'b0, (left == 16'd1) || (fill >= lim), tsv));
                end
                count_down();
            end else begin
                // start code, marker byte, or an unused phase value
                taken = taken + 16'd1;
                if (b != 8'h00 && taken < len) begin
                    left    = len - taken;
                    frag    = left > {4'd0, lim};
                    held_ts = ts;
                    fill    = 12'd0;
                    phase   = PH_HEAD;
                end else if (taken >= len) begin
                    close_unit();
                end
            end
            foreach (made[i]) begin
                if (i == made.size() - 1)
                    made[i].run_last = 1'b1;
                expected_pkt.push_back(made[i]);
            end
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        endfunction

        // Compare one output transfer with the oldest expectation
        function void check_payload(pkt_result_t seen);
            pkt_result_t want;
            if (expected_pkt.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got byte %h ts %h",
                             $time, seen.data, seen.ts);
                return;
            end
            want = expected_pkt.pop_front();
            if (seen.data !== want.data)
                report("pkt_byte", want.data, seen.data);
            if (seen.first !== want.first)
                report("pkt_first", want.first, seen.first);
            if (seen.last !== want.last)
                report("pkt_last", want.last, seen.last);
            if (seen.ts !== want.ts)
                report("ts_step", want.ts, seen.ts);
            if (seen.run_last !== want.run_last)
                report("run_last", want.run_last, seen.run_last);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [7:0] nal_byte;
    logic [15:0] nal_length;
    logic [31:0] ts_increment;
    logic cfg_valid;
    logic cfg_ready;
    logic [LIMIT_W-1:0] payload_limit;
    logic out_valid;
    logic out_ready;
    logic [7:0] pkt_byte;
    logic pkt_first;
    logic pkt_last;
    logic [31:0] ts_step;
    logic run_last;

    logic in_quiet;
    logic out_quiet;
    logic hold_off;
    int   idle_cycles;
    nal_item_t unit_q[$];

    frag_scoreboard sb = new();

    h264_nal_rtp_fragmenter_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .nal_byte     (nal_byte),
        .nal_length   (nal_length),
        .ts_increment (ts_increment),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .payload_limit(payload_limit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pkt_byte     (pkt_byte),
        .pkt_first    (pkt_first),
        .pkt_last     (pkt_last),
        .ts_step      (ts_step),
        .run_last     (run_last)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Record every transfer on the three channels
    always @(posedge clk)
    begin : monitor
        pkt_result_t seen;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.limit = payload_limit;
            if (in_valid && in_ready)
                sb.take_nal_byte(nal_byte, nal_length, ts_increment);
            if (out_valid && out_ready) begin
                seen.data     = pkt_byte;
                seen.first    = pkt_first;
                seen.last     = pkt_last;
                seen.ts       = ts_step;
                seen.run_last = run_last;
                sb.check_payload(seen);
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver: random stalls, quiet stretches, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                hold_off = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end else if (out_quiet) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= 23);
            end
        end
    end

    // Offer one byte, return at the edge where it transfers
    task automatic send_byte(input logic [7:0] b, input logic [15:0] len,
                             input logic [31:0] ts);
        if (!in_quiet) begin
            while ($urandom_range(99) < 23) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        nal_byte     <= b;
        nal_length   <= len;
        ts_increment <= ts;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_items(input int count);
        nal_item_t it;
        repeat (count) begin
            it = unit_q.pop_front();
            send_byte(it.data, it.len, it.ts);
        end
    endtask

    // Build one unit: start code zeros, marker, stripped bytes
    task automatic make_unit(input int zeros, input int body, input bit broken);
        logic [15:0] len;
        logic [31:0] ts;
        len = 16'(zeros + 1 + body);
        ts  = $urandom;
        // broken units declare fewer bytes than they carry
        if (broken)
            len = len - 16'($urandom_range(1, body));
        unit_q.delete();
        repeat (zeros) unit_q.push_back('{8'h00, len, ts});
        unit_q.push_back('{8'($urandom_range(1, 255)), len, ts});
        repeat (body) unit_q.push_back('{8'($urandom), len, ts});
    endtask

    // Stop offering and wait until every expected byte is out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_pkt.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [11:0] v);
        cfg_valid     <= 1'b1;
        payload_limit <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int ph;
        int sent;
        int kind;
        int zeros;
        logic [11:0] lim_pick;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        nal_byte      = 8'h00;
        nal_length    = 16'd0;
        ts_increment  = 32'd0;
        cfg_valid     = 1'b0;
        payload_limit = LIMIT_RESET;
        in_quiet      = 1'b0;
        out_quiet     = 1'b0;
        hold_off      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Length zero ends at once, zero byte and nonzero byte
        send_byte(8'h00, 16'h0000, 32'h0000_0000);
        send_byte(8'hFF, 16'h0000, 32'hFFFF_FFFF);
        // Unit over inside the start code
        send_byte(8'h00, 16'd2, 32'd0);
        send_byte(8'h00, 16'd2, 32'd0);
        // Nonzero byte just as the length is reached: still nothing sent
        send_byte(8'h65, 16'd1, 32'd0);
        // One-byte single packet at the reset limit, widest length on a zero
        send_byte(8'h00, 16'hFFFF, 32'h1234_5678);
        send_byte(8'h00, 16'd4, 32'h0000_0000);
        send_byte(8'h01, 16'd4, 32'hFFFF_FFFF);
        send_byte(8'hFF, 16'd4, 32'h0000_0000);

        // Limit below the floor acts as the floor: 17 bytes make two fragments
        wait_drained();
        write_limit(12'd0);
        make_unit(0, 17, 1'b0);
        send_items(unit_q.size());

        // Random phases, each with its own limit and idling mix
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case ($urandom_range(3))
                0: lim_pick = 12'($urandom_range(0, 15));
                1: lim_pick = 12'($urandom_range(16, 4095));
                default: lim_pick = 12'($urandom_range(16, 40));
            endcase
            if (ph == 0)
                lim_pick = LIMIT_MIN;
            else if (ph == 1)
                lim_pick = 12'd4095;
            else if (ph == 5)
                lim_pick = 12'd20;
            write_limit(lim_pick);
            in_quiet  = (ph == 2) || (ph == 3);
            out_quiet = (ph == 2);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (ph == 3 && sent == 0) begin
                    // receiver holds off while the sender keeps offering
                    hold_off = 1'b1;
                    make_unit(2, 45, 1'b0);
                end else if (ph == 5 && sent == 0) begin
                    // limit rewritten in the middle of a fragmented unit
                    make_unit(1, 50, 1'b0);
                    sent += unit_q.size();
                    send_items(26);
                    wait_drained();
                    write_limit(12'($urandom_range(16, 28)));
                end else begin
                    kind = $urandom_range(99);
                    if (kind < 80) begin
                        make_unit($urandom_range(0, 4), $urandom_range(1, 40), 1'b0);
                    end else if (kind < 88) begin
                        unit_q.delete();
                        unit_q.push_back('{8'h00, 16'($urandom), $urandom});
                    end else if (kind < 93) begin
                        zeros = $urandom_range(1, 4);
                        unit_q.delete();
                        repeat (zeros) unit_q.push_back('{8'h00, 16'(zeros), $urandom});
                    end else begin
                        make_unit($urandom_range(0, 3), $urandom_range(2, 30), 1'b1);
                    end
                    sent += unit_q.size();
                end
                if (ph == 3 && sent == 0)
                    sent += unit_q.size();
                send_items(unit_q.size());
            end
        end

        // Drain and let any stray output show up
        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_pkt.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
